// ----- rtl/sqd_pkg.sv -----
// Shared constants and helpers for the shortest-queue dispatcher.
// No dependencies; used by the top level and the stamp RAM.
package sqd_pkg;

  localparam int DEF_MAX_QUEUES  = 8;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 16;

  localparam int CFG_W   = 4;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 160;

  // Saturating 32-bit add for the running sums.
  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- rtl/shortest_queue_dispatch_wait_stats_core.sv -----
// Top level of the join-shortest-queue dispatcher with wait statistics.
// Depends on sqd_pkg and sqd_stamp_ram.
//
// Usage:
//   Each input word on the s_ channel is one tick: s_tdata[0] = arrive,
//   s_tdata[1] = serve. An arrival is stamped with the tick counter and joins
//   the shortest active queue (ties to the highest index); a service slot
//   pops the head of the longest active queue (ties to the highest index).
//   Every tick yields exactly one output word on the m_ channel carrying the
//   per-tick decisions and the running statistics.
//   cfg_we / cfg_wdata write num_queues (0 acts as 1, large values clamp);
//   write it only while the block is idle.
// Sequencing:
//   An input word is taken only while the sequencer is idle, so the next
//   tick is not taken until the previous one has been loaded into the
//   output register. The queue length registers have a single read port,
//   walked twice per tick (choice scan, then length scan), and the stamp
//   RAM has a single registered read port.
// Reset (rst, synchronous): queues empty, tick counter and statistics
//   cleared, min wait 16'hFFFF, num_queues = 1. The stamp RAM is not cleared;
//   only written entries are ever read.
// Stall: a finished word sits in the output register while m_tready is low;
//   the block still takes and processes the next tick and holds in its last
//   step until the output register frees.
module shortest_queue_dispatch_wait_stats_core #(
  parameter int MAX_QUEUES  = sqd_pkg::DEF_MAX_QUEUES,
  parameter int QUEUE_DEPTH = sqd_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = sqd_pkg::DEF_TIME_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sqd_pkg::CFG_W-1:0]     cfg_wdata,  // num_queues
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] arrive, [1] serve, [7:2] zero
  input  logic [sqd_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] served, [16:1] wait_time, [19:17] serve_queue, [22:20] arrive_queue,
  // [23] dropped, [39:24] total_arrivals, [55:40] total_served,
  // [71:56] min_wait, [87:72] max_wait, [119:88] wait_sum,
  // [124:120] max_length, [156:125] length_sum, [159:157] zero
  output logic [sqd_pkg::M_DATA_W-1:0]  m_tdata
);

  // Derived widths
  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;  // queue index
  localparam int NW = $clog2(MAX_QUEUES + 1);                      // queue count
  localparam int HW = $clog2(QUEUE_DEPTH);                         // head / slot
  localparam int CW = $clog2(QUEUE_DEPTH + 1);                     // length
  localparam int SW = CW + $clog2(MAX_QUEUES + 1);                 // length sum
  localparam int MW = (TIME_BITS > 16) ? TIME_BITS : 16;           // min/max wait
  localparam int DEPTH = MAX_QUEUES * QUEUE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;  // find shortest / longest
  localparam logic [3:0] S_ARR  = 4'd2;  // store arrival stamp
  localparam logic [3:0] S_SRV  = 4'd3;  // pop head, start stamp read
  localparam logic [3:0] S_WAIT = 4'd4;  // stamp arrives, form wait
  localparam logic [3:0] S_STAT = 4'd5;  // wait statistics
  localparam logic [3:0] S_LEN  = 4'd6;  // length sum / peak scan
  localparam logic [3:0] S_FIN  = 4'd7;  // length statistics, tick advance
  localparam logic [3:0] S_OUT  = 4'd8;  // load output register

  logic [3:0]  state;
  logic [sqd_pkg::CFG_W-1:0] num_queues;

  // Queue bookkeeping, one read port selected by the sequencer
  logic [CW-1:0] q_count [MAX_QUEUES];
  logic [HW-1:0] q_head  [MAX_QUEUES];
  logic [QW-1:0] idx;
  logic [QW-1:0] rd_q;
  logic [CW-1:0] count_rd;
  logic [HW-1:0] head_rd;

  // Per-tick working state
  logic          arr_f;
  logic          srv_f;
  logic          drop_f;
  logic          served_f;
  logic [QW-1:0] shortest;
  logic [QW-1:0] longest;
  logic [CW-1:0] min_len;
  logic [CW-1:0] max_len;
  logic [TIME_BITS-1:0] wait_val;
  logic [SW-1:0] len_sum;
  logic [CW-1:0] len_peak;

  // Running statistics
  logic [TIME_BITS-1:0] tick_count;
  logic [15:0]   arrival_total;
  logic [15:0]   served_total;
  logic [MW-1:0] wait_min;
  logic [MW-1:0] wait_max;
  logic [31:0]   wait_total;
  logic [CW-1:0] length_peak;
  logic [31:0]   length_total;

  // Stamp RAM ports
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [TIME_BITS-1:0] ram_rdata;

  logic [NW-1:0] act_n;
  logic [QW-1:0] last_q;
  logic [CW:0]   slot_sum;
  logic [HW-1:0] tail_slot;
  logic [HW-1:0] head_inc;
  logic          arr_ok;
  logic          srv_ok;
  logic          out_free;

  // Active queue count: zero acts as one, clamp at the maximum
  always_comb begin
    if (num_queues == '0) begin
      act_n = NW'(1);
    end else if (int'(num_queues) > MAX_QUEUES) begin
      act_n = NW'(MAX_QUEUES);
    end else begin
      act_n = NW'(num_queues);
    end
  end
  assign last_q = QW'(act_n - NW'(1));

  always_comb begin
    case (state)
      S_ARR:   rd_q = shortest;
      S_SRV:   rd_q = longest;
      default: rd_q = idx;
    endcase
  end
  assign count_rd = q_count[rd_q];
  assign head_rd  = q_head[rd_q];

  // Tail slot: head + count wraps once at most
  assign slot_sum  = (CW + 1)'(head_rd) + (CW + 1)'(count_rd);
  assign tail_slot = (slot_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                     HW'(slot_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc  = (CW'(head_rd) + CW'(1) == CW'(QUEUE_DEPTH)) ?
                     '0 : HW'(head_rd + HW'(1));

  assign arr_ok   = arr_f && (count_rd < CW'(QUEUE_DEPTH));
  assign srv_ok   = srv_f && (count_rd != '0);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  assign ram_we    = (state == S_ARR) && arr_ok;
  assign ram_waddr = AW'(int'(rd_q) * QUEUE_DEPTH + int'(tail_slot));
  assign ram_re    = (state == S_SRV) && srv_ok;
  assign ram_raddr = AW'(int'(rd_q) * QUEUE_DEPTH + int'(head_rd));

  sqd_stamp_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (TIME_BITS)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tick_count),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_queues <= sqd_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      num_queues <= cfg_wdata;
    end
  end

  // Sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      tick_count    <= '0;
      arrival_total <= '0;
      served_total  <= '0;
      wait_min      <= MW'(16'hFFFF);
      wait_max      <= '0;
      wait_total    <= '0;
      length_peak   <= '0;
      length_total  <= '0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        q_count[i] <= '0;
        q_head[i]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            arr_f    <= s_tdata[0];
            srv_f    <= s_tdata[1];
            drop_f   <= 1'b0;
            served_f <= 1'b0;
            wait_val <= '0;
            idx      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // First queue seeds both choices; later ties move to higher index
          if (idx == '0 || count_rd <= min_len) begin
            min_len  <= count_rd;
            shortest <= idx;
          end
          if (idx == '0 || count_rd >= max_len) begin
            max_len <= count_rd;
            longest <= idx;
          end
          if (idx == last_q) begin
            state <= S_ARR;
          end else begin
            idx <= idx + QW'(1);
          end
        end
        S_ARR: begin
          if (arr_f) begin
            if (arr_ok) begin
              q_count[rd_q] <= count_rd + CW'(1);
              if (arrival_total != 16'hFFFF) begin
                arrival_total <= arrival_total + 16'd1;
              end
            end else begin
              drop_f <= 1'b1;
            end
          end
          state <= S_SRV;
        end
        S_SRV: begin
          // Count here already includes this tick's arrival
          if (srv_ok) begin
            q_head[rd_q]  <= head_inc;
            q_count[rd_q] <= count_rd - CW'(1);
            served_f      <= 1'b1;
            if (served_total != 16'hFFFF) begin
              served_total <= served_total + 16'd1;
            end
          end
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (served_f) begin
            wait_val <= tick_count - ram_rdata;
          end
          state <= S_STAT;
        end
        S_STAT: begin
          if (served_f) begin
            if (MW'(wait_val) < wait_min) begin
              wait_min <= MW'(wait_val);
            end
            if (MW'(wait_val) > wait_max) begin
              wait_max <= MW'(wait_val);
            end
            wait_total <= sqd_pkg::sat_add32(wait_total, 32'(wait_val));
          end
          idx      <= '0;
          len_sum  <= '0;
          len_peak <= '0;
          state    <= S_LEN;
        end
        S_LEN: begin
          len_sum <= len_sum + SW'(count_rd);
          if (count_rd > len_peak) begin
            len_peak <= count_rd;
          end
          if (idx == last_q) begin
            state <= S_FIN;
          end else begin
            idx <= idx + QW'(1);
          end
        end
        S_FIN: begin
          if (len_peak > length_peak) begin
            length_peak <= len_peak;
          end
          length_total <= sqd_pkg::sat_add32(length_total, 32'(len_sum));
          tick_count   <= tick_count + TIME_BITS'(1);
          state        <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register can take the word
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata[0]       <= served_f;
      m_tdata[16:1]    <= served_f ? 16'(wait_val) : 16'd0;
      m_tdata[19:17]   <= served_f ? 3'(longest) : 3'd0;
      m_tdata[22:20]   <= arr_f ? 3'(shortest) : 3'd0;
      m_tdata[23]      <= arr_f && drop_f;
      m_tdata[39:24]   <= arrival_total;
      m_tdata[55:40]   <= served_total;
      m_tdata[71:56]   <= 16'(wait_min);
      m_tdata[87:72]   <= 16'(wait_max);
      m_tdata[119:88]  <= wait_total;
      m_tdata[124:120] <= 5'(length_peak);
      m_tdata[156:125] <= length_total;
      m_tdata[159:157] <= '0;
    end
  end

  // Checks
  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a tick is in progress");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_LEN) |-> (idx <= last_q))
    else $error("scan index beyond active queues");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_rd <= CW'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_min_before_service: assert property (@(posedge clk) disable iff (rst)
    (served_total == 16'd0) |-> (wait_min == MW'(16'hFFFF) && wait_max == '0))
    else $error("wait statistics moved without a service");

endmodule

// ----- rtl/sqd_stamp_ram.sv -----
// Arrival stamp store: one write port, one read port with registered data.
// Depends on sqd_pkg for default sizes.
module sqd_stamp_ram #(
  parameter int DEPTH = sqd_pkg::DEF_MAX_QUEUES * sqd_pkg::DEF_QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = sqd_pkg::DEF_TIME_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
